### rtl/grc_pkg.sv
package grc_pkg;

  // fixed point constants of the sine table build
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  // datapath widths
  localparam int DD_W   = 51;   // step length, up to the zero-direction marker
  localparam int SD_W   = 53;   // side distance accumulators
  localparam int DIST_W = 41;   // capped ray distance, Q16
  localparam int WALK_W = 10;

  localparam logic [DD_W-1:0]   STEP_INF = DD_W'(1) << 50;
  localparam logic [DIST_W-1:0] DIST_CAP = DIST_W'(1) << 40;
  localparam logic [WALK_W-1:0] WALK_CAP = WALK_W'(600);
  localparam logic [16:0]       HEIGHT_SAT = 17'h10000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PLAYER_X      = 3'd0,
    CFG_PLAYER_Y      = 3'd1,
    CFG_VIEW_ANGLE    = 3'd2,
    CFG_FIELD_OF_VIEW = 3'd3,
    CFG_SCREEN_COLS   = 3'd4,
    CFG_SCREEN_ROWS   = 3'd5,
    CFG_TEXTURE_WIDTH = 3'd6
  } cfg_idx_e;

  // sine over the first quadrant, q30 in and out, horner form of the series
  function automatic logic [63:0] quarter_sine(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] h;
    x2 = (x * x) >> 30;
    h  = Q30_ONE;
    h  = Q30_ONE - ((x2 * h) >> 30) / 64'd156;
    h  = Q30_ONE - ((x2 * h) >> 30) / 64'd110;
    h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
    h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
    h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
    h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
    return (x * h) >> 30;
  endfunction

endpackage

### rtl/grid_raycast_wall_column.sv
// wall-column raycaster over a tile map
// input channel (in_valid_i / in_stall_o): action 0 writes one map cell; action 1
// casts the ray of one screen column and gives one result.
// output channel (out_valid_o / out_stall_i): one result per cast, held in an
// output register, so a new item can start while the last result waits.
// the user must write configuration (cfg_we_i, cfg_index_i, cfg_data_i) only while
// idle; the block does not enforce this. a cast runs on one item at a time: a start,
// the angle divide, the sine rom reads, a step length divide per axis (skipped on an
// axis with zero direction), the walk load, the grid steps (each waits on the map
// memory read; a step off the map ends the walk without it), distance, the line
// height divide (skipped at zero distance) and the finish. the shared radix-2
// divider and the map memory read loop set how long a cast takes.
// after reset the map memory is cleared one cell a cycle; input stays stalled
// meanwhile, configuration writes are taken. if the receiver stalls, the result
// stays in the output register and the next cast finishes only once that
// transfer is done.
module grid_raycast_wall_column #(
  parameter int MAP_WIDTH    = 32,
  parameter int MAP_HEIGHT   = 32,
  parameter int TRIG_ENTRIES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  cell_x_i,
  input  logic [7:0]  cell_y_i,
  input  logic [3:0]  cell_value_i,
  input  logic [11:0] column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] ray_column_o,
  output logic [11:0] draw_start_o,
  output logic [11:0] draw_end_o,
  output logic [3:0]  texture_id_o,
  output logic [9:0]  texture_column_o,
  output logic        hit_side_o,
  output logic [15:0] wall_distance_o,
  output logic        left_map_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TIW   = $clog2(TRIG_ENTRIES);
  localparam int SD_W  = grc_pkg::SD_W;
  localparam int DD_W  = grc_pkg::DD_W;
  localparam int DIST_W = grc_pkg::DIST_W;
  localparam int WALK_W = grc_pkg::WALK_W;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ANGLE, S_DIVQ, S_ROMA, S_ROMB, S_ROMC, S_ROMD,
    S_DDX, S_DDXW, S_DDY, S_DDYW, S_INIT, S_STEP, S_CHECK, S_DIST,
    S_CORR, S_HIT, S_HGT, S_HGTW, S_DRAW, S_TEX, S_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0] px_q, py_q;
  logic [11:0] view_q;
  logic [10:0] fov_q;
  logic [12:0] cols_q, rows_q;
  logic [10:0] texw_q;

  // item and datapath registers
  logic [11:0]        col_q;
  logic [22:0]        colfov_q;
  logic [11:0]        offs_q, ang_q;
  logic signed [15:0] dx_q, dy_q, cd_q, rom_q;
  logic [DD_W-1:0]    ddx_q, ddy_q;
  logic [SD_W-1:0]    sdx_q, sdy_q;
  logic [9:0]         mx_q, my_q;
  logic [WALK_W-1:0]  n_q;
  logic               side_q, left_q;
  logic [3:0]         tile_q;
  logic [DIST_W-1:0]  dist_q, corr_q;
  logic [15:0]        prod16_q, wdist_q;
  logic [16:0]        height_q;
  logic [11:0]        ds_q, de_q;
  logic [26:0]        texmul_q;
  logic [9:0]         texx_q;
  logic               out_valid_q;

  // shared divider
  logic              div_run_q;
  logic [4:0]        div_cnt_q;
  logic [40:0]       div_rem_q, div_den_q;
  logic [31:0]       div_num_q, div_quo_q;
  logic              div_start;
  logic [31:0]       div_start_num;
  logic [40:0]       div_start_den;
  logic [41:0]       div_trial;
  logic              div_ge;

  // map memory
  logic [3:0]    tile_mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, clr_cnt_q;
  logic [3:0]    mem_wdata, mem_rdata_q;

  // sine rom
  logic [15:0]    sine_rom [TRIG_ENTRIES];
  logic [11:0]    rom_ang;
  logic [24:0]    rom_prod;
  logic [TIW-1:0] rom_idx;

  logic in_xfer, out_free, cell_in_map;

  function automatic logic [15:0] sine_entry(int unsigned i);
    logic [63:0] q, quad, x, v;
    q    = 64'(i) * 64'd4;
    quad = (q / 64'(TRIG_ENTRIES)) & 64'd3;
    x    = (q % 64'(TRIG_ENTRIES)) * grc_pkg::Q30_HALF_PI / 64'(TRIG_ENTRIES);
    if (quad[0]) begin
      x = grc_pkg::Q30_HALF_PI - x;
    end
    v = (grc_pkg::quarter_sine(x) + 64'd32768) >> 16;
    return quad[1] ? 16'(-v) : 16'(v);
  endfunction

  for (genvar g = 0; g < TRIG_ENTRIES; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign cell_in_map = (9'(cell_x_i) < 9'(MAP_WIDTH)) && (9'(cell_y_i) < 9'(MAP_HEIGHT));

  // effective screen and texture settings
  logic [12:0] cols_eff;
  logic [10:0] tw_eff;
  assign cols_eff = (cols_q == '0) ? 13'd1 : cols_q;
  assign tw_eff   = (texw_q == '0) ? 11'd1 : ((texw_q > 11'd1024) ? 11'd1024 : texw_q);

  // direction magnitudes
  logic [14:0] mag_x, mag_y;
  assign mag_x = dx_q[15] ? 15'(-dx_q) : dx_q[14:0];
  assign mag_y = dy_q[15] ? 15'(-dy_q) : dy_q[14:0];

  // ray angle from the column quotient
  logic [11:0] offs_d;
  assign offs_d = div_quo_q[11:0] - {2'b00, fov_q[10:1]};

  // rom address: cosine is sine a quarter turn on
  always_comb begin
    case (state_q)
      S_ROMA:  rom_ang = ang_q + 12'd1024;
      S_ROMB:  rom_ang = ang_q;
      S_ROMC:  rom_ang = offs_q + 12'd1024;
      default: rom_ang = ang_q;
    endcase
  end
  assign rom_prod = 25'(rom_ang) * 25'(TRIG_ENTRIES);
  assign rom_idx  = rom_prod[12 +: TIW];

  always_ff @(posedge clk_i) begin
    rom_q <= sine_rom[rom_idx];
  end

  // divider operand selection
  always_comb begin
    div_start     = 1'b0;
    div_start_num = '0;
    div_start_den = '0;
    case (state_q)
      S_ANGLE: begin
        div_start     = 1'b1;
        div_start_num = 32'(colfov_q);
        div_start_den = 41'(cols_eff);
      end
      S_DDX: begin
        div_start     = (mag_x != '0);
        div_start_num = 32'h4000_0000;
        div_start_den = 41'(mag_x);
      end
      S_DDY: begin
        div_start     = (mag_y != '0);
        div_start_num = 32'h4000_0000;
        div_start_den = 41'(mag_y);
      end
      S_HGT: begin
        div_start     = (corr_q != '0);
        div_start_num = {3'b000, rows_q, 16'h0000};
        div_start_den = corr_q;
      end
      default: ;
    endcase
  end

  assign div_trial = {div_rem_q, div_num_q[31]};
  assign div_ge    = div_trial >= {1'b0, div_den_q};

  // grid step
  logic        step_x, out_of_map;
  logic [9:0]  mx_n, my_n;
  assign step_x = sdx_q < sdy_q;
  assign mx_n = step_x ? mx_q + (dx_q[15] ? 10'h3FF : 10'd1) : mx_q;
  assign my_n = step_x ? my_q : my_q + (dy_q[15] ? 10'h3FF : 10'd1);
  assign out_of_map = mx_n[9] || my_n[9] || (mx_n[8:0] >= 9'(MAP_WIDTH))
                      || (my_n[8:0] >= 9'(MAP_HEIGHT));

  // map memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_xfer && !action_i && cell_in_map) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(32'(cell_y_i) * MAP_WIDTH + 32'(cell_x_i));
      mem_wdata = cell_value_i;
    end
  end
  assign mem_raddr = AW'(32'(my_n[7:0]) * MAP_WIDTH + 32'(mx_n[7:0]));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= tile_mem[mem_raddr];
  end

  // initial side distances
  logic [8:0]      fx9, fy9;
  logic [39:0]     mulx, muly;
  logic [SD_W-1:0] sdx_init, sdy_init;
  assign fx9  = dx_q[15] ? {1'b0, px_q[7:0]} : 9'd256 - {1'b0, px_q[7:0]};
  assign fy9  = dy_q[15] ? {1'b0, py_q[7:0]} : 9'd256 - {1'b0, py_q[7:0]};
  assign mulx = 40'(fx9) * 40'(ddx_q[30:0]);
  assign muly = 40'(fy9) * 40'(ddy_q[30:0]);
  assign sdx_init = ddx_q[50] ? SD_W'({fx9, 42'b0}) : SD_W'(mulx[39:8]);
  assign sdy_init = ddy_q[50] ? SD_W'({fy9, 42'b0}) : SD_W'(muly[39:8]);

  // distance, correction and hit point
  logic [SD_W-1:0] dist_raw;
  logic [55:0]     corr_mul;
  logic            cd_pos;
  logic [29:0]     hit_mul;
  assign dist_raw = side_q ? sdy_q - SD_W'(ddy_q) : sdx_q - SD_W'(ddx_q);
  assign cd_pos   = !cd_q[15] && (cd_q != '0);
  assign corr_mul = 56'(dist_q) * 56'(cd_q[14:0]);
  assign hit_mul  = 30'(side_q ? mag_x : mag_y) * dist_q[29:0];

  // wall rows and texture column
  logic [11:0] half;
  logic [15:0] hh;
  logic [16:0] de_sum, de_clip;
  logic [12:0] last_row;
  logic [15:0] frac, p_lo;
  logic [10:0] tex_t, tex_f;
  logic        flip;
  assign half     = rows_q[12:1];
  assign hh       = height_q[16:1];
  assign de_sum   = 17'(half) + 17'(hh);
  assign last_row = (rows_q == '0) ? 13'd0 : rows_q - 13'd1;
  assign de_clip  = (de_sum > 17'(last_row)) ? 17'(last_row) : de_sum;
  assign p_lo     = {side_q ? px_q[7:0] : py_q[7:0], 8'h00};
  assign frac     = (side_q ? dx_q[15] : dy_q[15]) ? p_lo - prod16_q : p_lo + prod16_q;
  assign tex_t    = texmul_q[26:16];
  assign flip     = (!side_q && !dx_q[15] && (dx_q != '0)) || (side_q && dy_q[15]);
  assign tex_f    = flip ? tw_eff - tex_t - 11'd1 : tex_t;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= '0;
      py_q   <= '0;
      view_q <= '0;
      fov_q  <= 11'd683;
      cols_q <= 13'd640;
      rows_q <= 13'd480;
      texw_q <= 11'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        grc_pkg::CFG_PLAYER_X:      px_q   <= cfg_data_i;
        grc_pkg::CFG_PLAYER_Y:      py_q   <= cfg_data_i;
        grc_pkg::CFG_VIEW_ANGLE:    view_q <= cfg_data_i[11:0];
        grc_pkg::CFG_FIELD_OF_VIEW: fov_q  <= cfg_data_i[10:0];
        grc_pkg::CFG_SCREEN_COLS:   cols_q <= cfg_data_i[12:0];
        grc_pkg::CFG_SCREEN_ROWS:   rows_q <= cfg_data_i[12:0];
        grc_pkg::CFG_TEXTURE_WIDTH: texw_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // control: sequencer, output valid, divider count, clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      div_run_q   <= 1'b0;
      div_cnt_q   <= '0;
      clr_cnt_q   <= '0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_start) begin
        div_run_q <= 1'b1;
        div_cnt_q <= 5'd31;
      end else if (div_run_q) begin
        div_cnt_q <= div_cnt_q - 5'd1;
        if (div_cnt_q == '0) begin
          div_run_q <= 1'b0;
        end
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: if (in_xfer && action_i) state_q <= S_ANGLE;
        S_ANGLE: state_q <= S_DIVQ;
        S_DIVQ:  if (!div_run_q) state_q <= S_ROMA;
        S_ROMA:  state_q <= S_ROMB;
        S_ROMB:  state_q <= S_ROMC;
        S_ROMC:  state_q <= S_ROMD;
        S_ROMD:  state_q <= S_DDX;
        S_DDX:   state_q <= (mag_x == '0) ? S_DDY : S_DDXW;
        S_DDXW:  if (!div_run_q) state_q <= S_DDY;
        S_DDY:   state_q <= (mag_y == '0) ? S_INIT : S_DDYW;
        S_DDYW:  if (!div_run_q) state_q <= S_INIT;
        S_INIT:  state_q <= S_STEP;
        S_STEP:  state_q <= out_of_map ? S_DIST : S_CHECK;
        S_CHECK: begin
          if (mem_rdata_q != '0 || n_q == grc_pkg::WALK_CAP) begin
            state_q <= S_DIST;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_DIST:  state_q <= S_CORR;
        S_CORR:  state_q <= S_HIT;
        S_HIT:   state_q <= S_HGT;
        S_HGT:   state_q <= (corr_q == '0) ? S_DRAW : S_HGTW;
        S_HGTW:  if (!div_run_q) state_q <= S_DRAW;
        S_DRAW:  state_q <= S_TEX;
        S_TEX:   state_q <= S_OUT;
        S_OUT:   if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divider datapath, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_num_q <= div_start_num;
      div_den_q <= div_start_den;
      div_quo_q <= '0;
    end else if (div_run_q) begin
      div_rem_q <= div_ge ? 41'(div_trial - {1'b0, div_den_q}) : div_trial[40:0];
      div_num_q <= {div_num_q[30:0], 1'b0};
      div_quo_q <= {div_quo_q[30:0], div_ge};
    end
  end

  // ray datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          col_q    <= column_i;
          colfov_q <= 23'(column_i) * 23'(fov_q);
        end
      end
      S_DIVQ: begin
        if (!div_run_q) begin
          offs_q <= offs_d;
          ang_q  <= view_q + offs_d;
        end
      end
      S_ROMB: dx_q <= rom_q;
      S_ROMC: dy_q <= rom_q;
      S_ROMD: cd_q <= rom_q;
      S_DDX:  if (mag_x == '0) ddx_q <= grc_pkg::STEP_INF;
      S_DDXW: if (!div_run_q) ddx_q <= DD_W'(div_quo_q);
      S_DDY:  if (mag_y == '0) ddy_q <= grc_pkg::STEP_INF;
      S_DDYW: if (!div_run_q) ddy_q <= DD_W'(div_quo_q);
      S_INIT: begin
        mx_q   <= {2'b00, px_q[15:8]};
        my_q   <= {2'b00, py_q[15:8]};
        sdx_q  <= sdx_init;
        sdy_q  <= sdy_init;
        n_q    <= '0;
        left_q <= 1'b0;
      end
      S_STEP: begin
        if (step_x) begin
          sdx_q  <= sdx_q + SD_W'(ddx_q);
          side_q <= 1'b0;
        end else begin
          sdy_q  <= sdy_q + SD_W'(ddy_q);
          side_q <= 1'b1;
        end
        mx_q   <= mx_n;
        my_q   <= my_n;
        n_q    <= n_q + WALK_W'(1);
        left_q <= out_of_map;
      end
      S_CHECK: begin
        tile_q <= mem_rdata_q;
        if (mem_rdata_q == '0 && n_q == grc_pkg::WALK_CAP) begin
          left_q <= 1'b1;
        end
      end
      S_DIST: begin
        dist_q <= (dist_raw > SD_W'(grc_pkg::DIST_CAP)) ? grc_pkg::DIST_CAP
                                                        : dist_raw[DIST_W-1:0];
      end
      S_CORR: corr_q <= cd_pos ? corr_mul[54:14] : '0;
      S_HIT: begin
        prod16_q <= hit_mul[29:14];
        wdist_q  <= (corr_q[40:8] > 33'hFFFF) ? 16'hFFFF : corr_q[23:8];
      end
      S_HGT:  if (corr_q == '0) height_q <= grc_pkg::HEIGHT_SAT;
      S_HGTW: begin
        if (!div_run_q) begin
          height_q <= (div_quo_q > 32'(grc_pkg::HEIGHT_SAT)) ? grc_pkg::HEIGHT_SAT
                                                            : div_quo_q[16:0];
        end
      end
      S_DRAW: begin
        ds_q     <= (16'(half) < hh) ? 12'd0 : 12'(16'(half) - hh);
        de_q     <= (de_clip > 17'd4095) ? 12'd4095 : de_clip[11:0];
        texmul_q <= 27'(frac) * 27'(tw_eff);
      end
      S_TEX: texx_q <= (tex_f >= tw_eff) ? 10'(tw_eff - 11'd1) : tex_f[9:0];
      S_OUT: begin
        if (out_free) begin
          ray_column_o     <= col_q;
          draw_start_o     <= ds_q;
          draw_end_o       <= de_q;
          texture_id_o     <= left_q ? 4'd0 : tile_q - 4'd1;
          texture_column_o <= texx_q;
          hit_side_o       <= side_q;
          wall_distance_o  <= wdist_q;
          left_map_o       <= left_q;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_run_q)
    else $error("divider started while busy");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_map_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("map write during a cast");

  a_rows_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> draw_start_o <= draw_end_o)
    else $error("draw start past draw end");

endmodule

### bench/grid_raycast_wall_column_tb.sv
`timescale 1ns / 1ps

module grid_raycast_wall_column_tb;

  localparam int MAP_W = 32;
  localparam int MAP_H = 32;
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;
  localparam int RANDOM_ITEMS = 600;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_CAST} row_kind_e;

  // register field of rows that write no register
  localparam grc_pkg::cfg_idx_e NO_REG = grc_pkg::CFG_PLAYER_X;

  typedef struct packed {
    logic [11:0] ray_column;
    logic [11:0] draw_start;
    logic [11:0] draw_end;
    logic [3:0]  texture_id;
    logic [9:0]  texture_column;
    logic        hit_side;
    logic [15:0] wall_distance;
    logic        left_map;
  } column_result_t;

  typedef struct {
    row_kind_e         kind;
    grc_pkg::cfg_idx_e reg_idx;
    logic [15:0]       reg_data;
    logic [7:0]        cx;
    logic [7:0]        cy;
    logic [3:0]        cval;
    logic [11:0]       col;
    logic              typed;
    column_result_t    want;
  } stim_row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic        action_i;
  logic [7:0]  cell_x_i, cell_y_i;
  logic [3:0]  cell_value_i;
  logic [11:0] column_i;
  logic        out_valid_o, out_stall_i;
  logic [11:0] ray_column_o, draw_start_o, draw_end_o;
  logic [3:0]  texture_id_o;
  logic [9:0]  texture_column_o;
  logic        hit_side_o;
  logic [15:0] wall_distance_o;
  logic        left_map_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  grid_raycast_wall_column DUT (.*);

  // shadow state of the raycaster
  int          sine_tab[4096];
  logic [3:0]  tiles[MAP_W*MAP_H];
  int unsigned pos_x, pos_y, heading, fov_w, n_cols, n_rows, tex_w;

  column_result_t expected_columns[$];
  int errs;
  int burst_left;
  int stall_mode;

  // sine table, q30 series on the first quadrant, rounded to q14
  function automatic void build_sine_tab();
    longint unsigned divs[6];
    longint unsigned q, quad, x, x2, h, v;
    divs = '{156, 110, 72, 42, 20, 6};
    for (int i = 0; i < 4096; i++) begin
      q = longint'(i) * 4;
      quad = (q / 4096) & 3;
      x = (q % 4096) * 64'd1686629713 / 4096;
      if (quad[0]) x = 64'd1686629713 - x;
      x2 = (x * x) >> 30;
      h = 64'd1073741824;
      for (int k = 0; k < 6; k++) h = 64'd1073741824 - ((x2 * h) >> 30) / divs[k];
      v = (((x * h) >> 30) + 32768) >> 16;
      sine_tab[i] = (quad >= 2) ? -int'(v) : int'(v);
    end
  endfunction

  function automatic longint unsigned step_length(int d);
    longint unsigned m;
    m = (d < 0) ? -d : d;
    return (m == 0) ? (64'd1 << 50) : (64'd1 << 30) / m;
  endfunction

  // dda walk and wall column for one screen column
  function automatic column_result_t cast_column(logic [11:0] col);
    column_result_t r;
    int unsigned cols, offs, ang, tw, texx;
    int dx, dy, mx, my, sx, sy, cd, d, n;
    longint unsigned ddx, ddy, sdx, sdy, ray_dist, corr, height, prod, p, hit, frac;
    longint ds, de, last;
    logic side, left;
    logic [3:0] tile;
    cols = (n_cols != 0) ? n_cols : 1;
    offs = (int'(col) * fov_w) / cols - (fov_w >> 1);
    ang = (heading + offs) & 4095;
    dx = sine_tab[(ang + 1024) & 4095];
    dy = sine_tab[ang];
    ddx = step_length(dx);
    ddy = step_length(dy);
    mx = pos_x >> 8;
    my = pos_y >> 8;
    if (dx < 0) begin sx = -1; sdx = ((pos_x & 255) * ddx) >> 8; end
    else begin sx = 1; sdx = ((256 - (pos_x & 255)) * ddx) >> 8; end
    if (dy < 0) begin sy = -1; sdy = ((pos_y & 255) * ddy) >> 8; end
    else begin sy = 1; sdy = ((256 - (pos_y & 255)) * ddy) >> 8; end
    side = 0; left = 0; tile = 0;
    for (n = 0; n < 600; n++) begin
      if (sdx < sdy) begin sdx += ddx; mx += sx; side = 0; end
      else begin sdy += ddy; my += sy; side = 1; end
      if (mx < 0 || mx >= MAP_W || my < 0 || my >= MAP_H) begin
        left = 1;
        break;
      end
      tile = tiles[my * MAP_W + mx];
      if (tile != 0) break;
    end
    if (n >= 600) left = 1;
    if (left) tile = 0;
    ray_dist = side ? sdy - ddy : sdx - ddx;
    if (ray_dist > (64'd1 << 40)) ray_dist = 64'd1 << 40;
    cd = sine_tab[(offs + 1024) & 4095];
    corr = (cd > 0) ? (ray_dist * longint'(cd)) >> 14 : 0;
    if (corr == 0) height = 65536;
    else begin
      height = (longint'(n_rows) << 16) / corr;
      if (height > 65536) height = 65536;
    end
    ds = longint'(n_rows / 2) - longint'(height / 2);
    de = longint'(n_rows / 2) + longint'(height / 2);
    last = (n_rows != 0) ? longint'(n_rows) - 1 : 0;
    if (ds < 0) ds = 0;
    if (de > last) de = last;
    r.draw_start = (ds > 4095) ? 12'd4095 : 12'(ds);
    r.draw_end = (de < 0) ? 12'd0 : (de > 4095) ? 12'd4095 : 12'(de);
    // texel column from the hit point along the wall
    d = side ? dx : dy;
    p = longint'(side ? pos_x : pos_y) << 8;
    prod = (longint'(d < 0 ? -d : d) * ray_dist) >> 14;
    hit = (d < 0) ? p - prod : p + prod;
    frac = hit & 64'hFFFF;
    tw = (tex_w == 0) ? 1 : (tex_w > 1024) ? 1024 : tex_w;
    texx = (frac * tw) >> 16;
    if ((!side && dx > 0) || (side && dy < 0)) texx = tw - texx - 1;
    if (texx >= tw) texx = tw - 1;
    r.ray_column = col;
    r.texture_id = (tile != 0) ? tile - 4'd1 : 4'd0;
    r.texture_column = texx[9:0];
    r.hit_side = side;
    r.wall_distance = ((corr >> 8) > 65535) ? 16'hFFFF : 16'(corr >> 8);
    r.left_map = left;
    return r;
  endfunction

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("grid_raycast_wall_column_tb: done, errors");
    $finish;
  end

  // receiver stall pattern
  int stall_hold;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold <= 0;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: begin
          if (stall_hold == 0) begin
            out_stall_i <= ~out_stall_i;
            stall_hold <= $urandom_range(1, 40);
          end else begin
            stall_hold <= stall_hold - 1;
          end
        end
      endcase
    end
  end

  // result check against the oldest expected column
  always @(posedge clk_i) begin
    column_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{ray_column_o, draw_start_o, draw_end_o, texture_id_o, texture_column_o,
              hit_side_o, wall_distance_o, left_map_o};
      if (expected_columns.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result column %0d", got.ray_column);
      end else begin
        want = expected_columns.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= 10) begin
            $display("mismatch col %0d exp: ds %0d de %0d tex %0d tc %0d side %0d %s",
                     want.ray_column, want.draw_start, want.draw_end, want.texture_id,
                     want.texture_column, want.hit_side,
                     $sformatf("dist %0d left %0d", want.wall_distance, want.left_map));
            $display("  got col %0d: ds %0d de %0d tex %0d tc %0d side %0d %s",
                     got.ray_column, got.draw_start, got.draw_end, got.texture_id,
                     got.texture_column, got.hit_side,
                     $sformatf("dist %0d left %0d", got.wall_distance, got.left_map));
          end
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(logic act, logic [7:0] x, logic [7:0] y, logic [3:0] v,
                           logic [11:0] col, logic typed, column_result_t want);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i = 1'b1;
    action_i = act;
    cell_x_i = x;
    cell_y_i = y;
    cell_value_i = v;
    column_i = col;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    if (act == ACT_CAST)
      expected_columns.insert(expected_columns.size(), typed ? want : cast_column(col));
    else if (x < MAP_W && y < MAP_H) tiles[y * MAP_W + x] = v;
    @(negedge clk_i);
  endtask

  // let everything drain before touching registers
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(grc_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      grc_pkg::CFG_PLAYER_X:      pos_x = data;
      grc_pkg::CFG_PLAYER_Y:      pos_y = data;
      grc_pkg::CFG_VIEW_ANGLE:    heading = data & 16'hFFF;
      grc_pkg::CFG_FIELD_OF_VIEW: fov_w = data & 16'h7FF;
      grc_pkg::CFG_SCREEN_COLS:   n_cols = data & 16'h1FFF;
      grc_pkg::CFG_SCREEN_ROWS:   n_rows = data & 16'h1FFF;
      grc_pkg::CFG_TEXTURE_WIDTH: tex_w = data & 16'h7FF;
      default: ;
    endcase
  endtask

  // mostly in range with the bounds often, rarely anything the register holds
  function automatic int unsigned pick_reg(int unsigned lo, int unsigned hi, int unsigned full);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      2: return $urandom_range(0, full);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  stim_row_t dir_tab[$];
  column_result_t none;

  // append one row to the directed table
  function automatic void add_row(stim_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  initial begin
    int sent, xi, yi;
    logic [7:0] wx, wy;
    none = '0;
    errs = 0;
    burst_left = 0;
    stall_mode = 0;
    in_valid_i = 0; action_i = 0; cell_x_i = 0; cell_y_i = 0; cell_value_i = 0;
    column_i = 0; cfg_we_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    pos_x = 0; pos_y = 0; heading = 0; fov_w = 683; n_cols = 640; n_rows = 480; tex_w = 64;
    foreach (tiles[i]) tiles[i] = 0;
    build_sine_tab();
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed rows: reset state, ignored writes, axis rays, odd screen settings
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd0, 1'b1,
              '{12'd0, 12'd0, 12'd479, 4'd0, 10'd63, 1'b1, 16'd0, 1'b1}});
    add_row('{ROW_WRITE, NO_REG, 16'd0, 8'd255, 8'd255, 4'd15, 12'd0, 1'b0, none});
    add_row('{ROW_WRITE, NO_REG, 16'd0, 8'd32, 8'd5, 4'd7, 12'd0, 1'b0, none});
    add_row('{ROW_WRITE, NO_REG, 16'd0, 8'd5, 8'd32, 4'd7, 12'd0, 1'b0, none});
    add_row('{ROW_WRITE, NO_REG, 16'd0, 8'd6, 8'd3, 4'd15, 12'd0, 1'b0, none});
    add_row('{ROW_WRITE, NO_REG, 16'd0, 8'd31, 8'd31, 4'd1, 12'd0, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd4095, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_PLAYER_X, 16'h0380,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_PLAYER_Y, 16'h0380,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd320, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd639, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_VIEW_ANGLE, 16'd1024,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd320, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_FIELD_OF_VIEW, 16'd2047,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_SCREEN_COLS, 16'd0,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd1, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_SCREEN_ROWS, 16'd0,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_TEXTURE_WIDTH, 16'd0,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_SCREEN_ROWS, 16'h1FFF,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_TEXTURE_WIDTH, 16'h7FF,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CFG, grc_pkg::CFG_PLAYER_X, 16'hFF80,
              8'd0, 8'd0, 4'd0, 12'd0, 1'b0, none});
    add_row('{ROW_CAST, NO_REG, 16'd0, 8'd0, 8'd0, 4'd0, 12'd2048, 1'b0, none});

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_data);
        end
        ROW_WRITE: send_item(ACT_WRITE, dir_tab[i].cx, dir_tab[i].cy, dir_tab[i].cval,
                             12'd0, 1'b0, none);
        default: send_item(ACT_CAST, 8'd0, 8'd0, 4'd0, dir_tab[i].col,
                           dir_tab[i].typed, dir_tab[i].want);
      endcase
    end

    // walls around the map so that most rays hit something
    for (int k = 0; k < MAP_W; k++) begin
      send_item(ACT_WRITE, 8'(k), 8'd0, 4'($urandom_range(1, 15)), 12'd0, 1'b0, none);
      send_item(ACT_WRITE, 8'(k), 8'(MAP_H - 1), 4'($urandom_range(1, 15)), 12'd0, 1'b0, none);
      send_item(ACT_WRITE, 8'd0, 8'(k), 4'($urandom_range(1, 15)), 12'd0, 1'b0, none);
      send_item(ACT_WRITE, 8'(MAP_W - 1), 8'(k), 4'($urandom_range(1, 15)), 12'd0, 1'b0, none);
    end
    sent = 4 * MAP_W;

    // random phases: new settings, then a mix of map writes and casts
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      stall_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        write_reg(grc_pkg::CFG_PLAYER_X, 16'($urandom_range(0, 65535)));
        write_reg(grc_pkg::CFG_PLAYER_Y, 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(grc_pkg::CFG_PLAYER_X, 16'($urandom_range(256, (MAP_W - 1) * 256 - 1)));
        write_reg(grc_pkg::CFG_PLAYER_Y, 16'($urandom_range(256, (MAP_H - 1) * 256 - 1)));
      end
      write_reg(grc_pkg::CFG_VIEW_ANGLE, 16'(pick_reg(0, 4095, 4095)));
      write_reg(grc_pkg::CFG_FIELD_OF_VIEW, 16'(pick_reg(1, 2047, 2047)));
      write_reg(grc_pkg::CFG_SCREEN_COLS, 16'(pick_reg(1, 4096, 8191)));
      write_reg(grc_pkg::CFG_SCREEN_ROWS, 16'(pick_reg(1, 4096, 8191)));
      write_reg(grc_pkg::CFG_TEXTURE_WIDTH, 16'(pick_reg(1, 1024, 2047)));
      repeat ($urandom_range(20, 60)) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            wx = 8'($urandom_range(0, 255));
            wy = 8'($urandom_range(0, 255));
          end else begin
            xi = $urandom_range(1, MAP_W - 2);
            yi = $urandom_range(1, MAP_H - 2);
            wx = 8'(xi);
            wy = 8'(yi);
          end
          send_item(ACT_WRITE, wx, wy, 4'($urandom_range(0, 15)), 12'd0, 1'b0, none);
        end else if ($urandom_range(0, 7) == 0 || n_cols == 0) begin
          send_item(ACT_CAST, 8'd0, 8'd0, 4'd0, 12'($urandom_range(0, 4095)), 1'b0, none);
        end else begin
          send_item(ACT_CAST, 8'd0, 8'd0, 4'd0,
                    12'($urandom_range(0, (n_cols > 4096 ? 4096 : n_cols) - 1)), 1'b0, none);
        end
        sent++;
      end
    end

    // drain and finish
    in_valid_i = 1'b0;
    while (expected_columns.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errs == 0 && expected_columns.size() == 0)
      $display("grid_raycast_wall_column_tb: done, clean");
    else
      $display("grid_raycast_wall_column_tb: done, errors");
    $finish;
  end

endmodule
